// ----- rtl/core/disparity_to_point_reprojection_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the disparity to point reprojection core
// Invariant and same-cycle implication checks, reported through $error.
// ---------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_REPROJECTION_CORE_ASSERT_SVH
`define DISPARITY_TO_POINT_REPROJECTION_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define DRP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("drp: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define DRP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drp: implication violated");

`endif

// ----- rtl/core/drp_pkg.sv -----
// ---------------------------------------------------------------------------
// drp_pkg
// Shared widths, register codes and stage structs of the reprojection core.
// ---------------------------------------------------------------------------
package drp_pkg;

  localparam int BASE_W   = 32;
  localparam int FOCAL_W  = 24;
  localparam int CX_W     = 24;
  localparam int TOP_W    = 12;
  localparam int GRAY_W   = 8;
  localparam int DISP_W   = 16;
  localparam int COORD_W  = 12;
  localparam int ROW_OUT_W = 13;
  localparam int DEPTH_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Numerator magnitude, divisor and quotient widths of the divider lanes.
  localparam int NUM_W  = 56;
  localparam int DIV_W  = 35;
  localparam int QUO_W  = 32;
  localparam int MM_SCALE = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE = 3'd0,
    REG_FOCAL    = 3'd1,
    REG_LEFT_CX  = 3'd2,
    REG_LEFT_CY  = 3'd3,
    REG_RIGHT_CX = 3'd4,
    REG_MM_MODE  = 3'd5,
    REG_TOP      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [BASE_W-1:0]  baseline;
    logic [FOCAL_W-1:0] focal;
    logic [CX_W-1:0]    left_cx;
    logic [CX_W-1:0]    left_cy;
    logic [CX_W-1:0]    right_cx;
    logic               mm;
    logic [TOP_W-1:0]   top;
  } cfg_t;

  // Per-pixel data that bypasses the divider arithmetic.
  typedef struct packed {
    logic [GRAY_W-1:0]    gray;
    logic [ROW_OUT_W-1:0] drow;
    logic                 neg_x;
  } side_t;

  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [NUM_W-1:0] num_z;
    logic [DIV_W-1:0] div_p;
    logic [DIV_W-1:0] div_d;
    logic             neg_y;
    logic             ok;
    logic             mm;
    side_t            side;
  } f2d_t;

  typedef struct packed {
    logic [QUO_W-1:0] q;
    logic             ovf;
  } quo_t;

endpackage

// ----- rtl/core/drp_front.sv -----
// ---------------------------------------------------------------------------
// drp_front
// Three register stages: offsets and divisor, products, magnitudes.
// ---------------------------------------------------------------------------
module drp_front import drp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  cfg_t                      cfg,
  input  logic                      vld_in,
  input  logic [GRAY_W-1:0]         gray,
  input  logic signed [DISP_W-1:0]  disparity_q4,
  input  logic [COORD_W-1:0]        column,
  input  logic [COORD_W-1:0]        row,
  output f2d_t                      f2d
);

  // Stage 1 combinational: divisor in Q8 and principal point offsets.
  logic signed [25:0] c_off;
  logic signed [25:0] d_full;
  logic signed [25:0] ax_full;
  logic signed [25:0] ay_full;
  logic               ok_full;

  assign c_off = (cfg.right_cx != '0 && cfg.left_cx != '0)
               ? $signed({2'b00, cfg.right_cx}) - $signed({2'b00, cfg.left_cx})
               : '0;
  assign d_full  = $signed({{6{disparity_q4[DISP_W-1]}}, disparity_q4, 4'b0000}) + c_off;
  assign ax_full = $signed({6'b0, column, 8'b0}) - $signed({2'b00, cfg.left_cx});
  assign ay_full = $signed({6'b0, row, 8'b0}) - $signed({2'b00, cfg.left_cy});
  assign ok_full = (disparity_q4 > 0) && (cfg.baseline != '0) && (cfg.focal != '0)
                && (d_full > 0);

  logic               s1_vld;
  logic               s1_ok;
  logic               s1_mm;
  logic [24:0]        s1_d;
  logic signed [25:0] s1_ax;
  logic signed [25:0] s1_ay;
  side_t              s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok        <= ok_full;
      s1_mm        <= cfg.mm;
      s1_d         <= d_full[24:0];
      s1_ax        <= ax_full;
      s1_ay        <= ay_full;
      s1_side.gray <= gray;
      s1_side.drow <= ROW_OUT_W'(row) + ROW_OUT_W'(cfg.top);
      s1_side.neg_x <= 1'b0;
    end
  end

  // Stage 2: one product per lane, divisor scaled for millimetres.
  logic signed [58:0] nx_full;
  logic signed [58:0] ny_full;
  logic [NUM_W-1:0]   nz_full;
  logic [DIV_W-1:0]   dp_full;

  assign nx_full = s1_ax * $signed({1'b0, cfg.baseline});
  assign ny_full = s1_ay * $signed({1'b0, cfg.baseline});
  assign nz_full = NUM_W'(cfg.focal) * NUM_W'(cfg.baseline);
  assign dp_full = s1_mm ? DIV_W'(s1_d) * DIV_W'(MM_SCALE) : DIV_W'(s1_d);

  logic               s2_vld;
  logic               s2_ok;
  logic               s2_mm;
  logic signed [58:0] s2_nx;
  logic signed [58:0] s2_ny;
  logic [NUM_W-1:0]   s2_nz;
  logic [DIV_W-1:0]   s2_dp;
  logic [DIV_W-1:0]   s2_dd;
  side_t              s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ok   <= s1_ok;
      s2_mm   <= s1_mm;
      s2_nx   <= nx_full;
      s2_ny   <= ny_full;
      s2_nz   <= nz_full;
      s2_dp   <= dp_full;
      s2_dd   <= DIV_W'(s1_d);
      s2_side <= s1_side;
    end
  end

  // Stage 3: sign and magnitude for the unsigned dividers.
  logic [58:0] nx_neg;
  logic [58:0] ny_neg;

  assign nx_neg = 59'(-s2_nx);
  assign ny_neg = 59'(-s2_ny);

  always_ff @(posedge clk) begin
    if (rst) begin
      f2d.vld <= 1'b0;
    end else if (en) begin
      f2d.vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2d.num_x      <= s2_nx[58] ? nx_neg[NUM_W-1:0] : s2_nx[NUM_W-1:0];
      f2d.num_y      <= s2_ny[58] ? ny_neg[NUM_W-1:0] : s2_ny[NUM_W-1:0];
      f2d.num_z      <= s2_nz;
      f2d.div_p      <= s2_dp;
      f2d.div_d      <= s2_dd;
      f2d.neg_y      <= s2_ny[58];
      f2d.ok         <= s2_ok;
      f2d.mm         <= s2_mm;
      f2d.side.gray  <= s2_side.gray;
      f2d.side.drow  <= s2_side.drow;
      f2d.side.neg_x <= s2_nx[58];
    end
  end

endmodule

// ----- rtl/core/drp_div.sv -----
// ---------------------------------------------------------------------------
// drp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ---------------------------------------------------------------------------
module drp_div import drp_pkg::*; #(
  parameter int NW = NUM_W,
  parameter int DW = DIV_W,
  parameter int QW = QUO_W,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          vld_out,
  output quo_t          quo,
  output logic [TW-1:0] tag_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          vld   [0:QW];
  logic [NW-1:0] rem   [0:QW];
  logic [QW-1:0] qp    [0:QW];
  logic [DW-1:0] den_p [0:QW];
  logic          ovf_p [0:QW];
  logic [TW-1:0] tag_p [0:QW];

  // Head stage: quotient needs more than QW bits when num >= den * 2^QW.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num;
      qp[0]    <= '0;
      den_p[0] <= den;
      ovf_p[0] <= CW'(num) >= (CW'(den) << QW);
      tag_p[0] <= tag_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BIT = QW - 1 - s;
    localparam logic [QW-1:0] MASK = QW'(1) << BIT;

    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(den_p[s]) << BIT;
    assign ge    = CW'(rem[s]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]   <= ge ? rem[s] - trial[NW-1:0] : rem[s];
        qp[s+1]    <= ge ? (qp[s] | MASK) : qp[s];
        den_p[s+1] <= den_p[s];
        ovf_p[s+1] <= ovf_p[s];
        tag_p[s+1] <= tag_p[s];
      end
    end
  end

  assign vld_out = vld[QW];
  assign quo.q   = qp[QW];
  assign quo.ovf = ovf_p[QW];
  assign tag_out = tag_p[QW];

endmodule

// ----- rtl/core/drp_back.sv -----
// ---------------------------------------------------------------------------
// drp_back
// Sign, saturation, masking of invalid points and the output register.
// ---------------------------------------------------------------------------
module drp_back import drp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  quo_t                 qx,
  input  quo_t                 qy,
  input  quo_t                 qz,
  input  quo_t                 qd,
  input  side_t                side,
  input  logic                 neg_y,
  input  logic                 ok,
  input  logic                 mm,
  output logic                 vld_out,
  output logic [GRAY_W-1:0]    gray_out,
  output logic signed [31:0]   point_x,
  output logic signed [31:0]   point_y,
  output logic signed [31:0]   point_z,
  output logic                 point_valid,
  output logic [DEPTH_W-1:0]   depth_word,
  output logic [ROW_OUT_W-1:0] depth_row
);

  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  function automatic logic [31:0] sat_signed(quo_t m, logic neg);
    logic big;
    big = m.ovf || (neg ? (m.q > INT_MIN) : m.q[31]);
    if (big) begin
      return neg ? INT_MIN : INT_MAX;
    end
    return neg ? 32'(-m.q) : m.q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_out    <= side.gray;
      depth_row   <= side.drow;
      point_valid <= ok;
      point_x     <= ok ? sat_signed(qx, side.neg_x) : '0;
      point_y     <= ok ? sat_signed(qy, neg_y) : '0;
      point_z     <= ok ? sat_signed(qz, 1'b0) : '0;
      // Metric depth is the integer part of Z before the millimetre scale.
      depth_word  <= (ok && mm && !qd.ovf) ? qd.q[QUO_W-1 -: DEPTH_W] : '0;
    end
  end

endmodule

// ----- rtl/core/disparity_to_point_reprojection_core.sv -----
// ---------------------------------------------------------------------------
// disparity_to_point_reprojection_core
// Reprojects a stream of disparity pixels to saturated Q16.16 3-D points.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the pixel channel (pixel_valid / pixel_stall) carrying
//   gray, disparity_q4, column and row; a request is taken on a clock edge
//   with valid high and stall low. One point leaves on the result channel
//   (result_valid / result_stall) for every pixel, in order.
//   Throughput is one pixel per clock while the receiver does not stall. The
//   pipeline is three front stages (offsets, products, magnitudes), a head
//   stage plus 32 quotient stages in each of the four divider lanes, and the
//   output register. The 32 one-bit divider stages set the depth.
//   Registers are written on the cfg channel (cfg_valid / cfg_ready, index
//   and data); cfg_ready is always high. Write them only while no pixel is
//   in flight.
//   Synchronous reset empties every stage and sets all registers to zero
//   except millimetre mode, which comes up set.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   pixel_stall is raised in the same cycle; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "disparity_to_point_reprojection_core_assert.svh"

module disparity_to_point_reprojection_core import drp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel requests
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [GRAY_W-1:0]      gray,
  input  logic signed [DISP_W-1:0] disparity_q4,
  input  logic [COORD_W-1:0]     column,
  input  logic [COORD_W-1:0]     row,
  // point results
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [GRAY_W-1:0]      gray_out,
  output logic signed [31:0]     point_x,
  output logic signed [31:0]     point_y,
  output logic signed [31:0]     point_z,
  output logic                   point_valid,
  output logic [DEPTH_W-1:0]     depth_word,
  output logic [ROW_OUT_W-1:0]   depth_row
);

  // Register file. Only the mode bit has a nonzero reset.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline <= '0;
      cfg.focal    <= '0;
      cfg.left_cx  <= '0;
      cfg.left_cy  <= '0;
      cfg.right_cx <= '0;
      cfg.mm       <= 1'b1;
      cfg.top      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_BASELINE: cfg.baseline <= cfg_data[BASE_W-1:0];
        REG_FOCAL:    cfg.focal    <= cfg_data[FOCAL_W-1:0];
        REG_LEFT_CX:  cfg.left_cx  <= cfg_data[CX_W-1:0];
        REG_LEFT_CY:  cfg.left_cy  <= cfg_data[CX_W-1:0];
        REG_RIGHT_CX: cfg.right_cx <= cfg_data[CX_W-1:0];
        REG_MM_MODE:  cfg.mm       <= cfg_data[0];
        REG_TOP:      cfg.top      <= cfg_data[TOP_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  // Whole pipeline advances unless a finished point is held by the receiver.
  logic en;

  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;

  f2d_t f2d;

  drp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .vld_in       (pixel_valid),
    .gray         (gray),
    .disparity_q4 (disparity_q4),
    .column       (column),
    .row          (row),
    .f2d          (f2d)
  );

  // Four divider lanes of equal depth. X carries the pass-through side
  // data, the others carry one flag each so that all stay in lockstep.
  logic  vld_x, vld_y, vld_z, vld_d;
  quo_t  qx, qy, qz, qd;
  side_t side_q;
  logic  neg_y_q, ok_q, mm_q;

  drp_div #(
    .NW (NUM_W), .DW (DIV_W), .QW (QUO_W), .TW ($bits(side_t))
  ) u_div_x (
    .clk (clk), .rst (rst), .en (en),
    .vld_in (f2d.vld), .num (f2d.num_x), .den (f2d.div_p), .tag_in (f2d.side),
    .vld_out (vld_x), .quo (qx), .tag_out (side_q)
  );

  drp_div #(
    .NW (NUM_W), .DW (DIV_W), .QW (QUO_W), .TW (1)
  ) u_div_y (
    .clk (clk), .rst (rst), .en (en),
    .vld_in (f2d.vld), .num (f2d.num_y), .den (f2d.div_p), .tag_in (f2d.neg_y),
    .vld_out (vld_y), .quo (qy), .tag_out (neg_y_q)
  );

  drp_div #(
    .NW (NUM_W), .DW (DIV_W), .QW (QUO_W), .TW (1)
  ) u_div_z (
    .clk (clk), .rst (rst), .en (en),
    .vld_in (f2d.vld), .num (f2d.num_z), .den (f2d.div_p), .tag_in (f2d.ok),
    .vld_out (vld_z), .quo (qz), .tag_out (ok_q)
  );

  // Depth lane divides by the unscaled divisor: its upper half is the
  // integer part of Z, and overflow marks depth past the 16-bit word.
  drp_div #(
    .NW (NUM_W), .DW (DIV_W), .QW (QUO_W), .TW (1)
  ) u_div_d (
    .clk (clk), .rst (rst), .en (en),
    .vld_in (f2d.vld), .num (f2d.num_z), .den (f2d.div_d), .tag_in (f2d.mm),
    .vld_out (vld_d), .quo (qd), .tag_out (mm_q)
  );

  drp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .vld_in      (vld_x),
    .qx          (qx),
    .qy          (qy),
    .qz          (qz),
    .qd          (qd),
    .side        (side_q),
    .neg_y       (neg_y_q),
    .ok          (ok_q),
    .mm          (mm_q),
    .vld_out     (result_valid),
    .gray_out    (gray_out),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_valid (point_valid),
    .depth_word  (depth_word),
    .depth_row   (depth_row)
  );

  // Lanes must never drift apart.
  `DRP_ASSERT_ALWAYS(a_lanes_aligned, clk, rst, (vld_x == vld_y) && (vld_x == vld_z) && (vld_x == vld_d))
  // An invalid point carries no coordinates and no depth.
  `DRP_ASSERT_IMPLY(a_invalid_zero, clk, rst, result_valid && !point_valid, (point_x == 0) && (point_y == 0) && (point_z == 0) && (depth_word == '0))
  // A depth word appears only for valid points in millimetre mode.
  `DRP_ASSERT_IMPLY(a_depth_mode, clk, rst, result_valid && (depth_word != '0), point_valid && cfg.mm)

endmodule
